// ===== sv/ppdec_pkg.sv =====
// Shared widths, constants and types of the PPM pulse-train decoder.
// No dependencies; used by every module of the decoder.
package ppdec_pkg;

    localparam int SAMPLE_W = 48;
    localparam int HIGH_W   = 32;
    localparam int CHAN_W   = 8;
    localparam int THRESH_W = 32;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 32'd3000;
    localparam logic [CHAN_W-1:0]   CHAN_MAX     = 8'd255;

    localparam int FIFO_DEPTH_DEFAULT = 2;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = HIGH_W + CHAN_W + 2 * SAMPLE_W;

    // A closed period as seen by the front end.
    typedef struct packed {
        logic [SAMPLE_W-1:0] start;
        logic [SAMPLE_W-1:0] rise;
        logic [SAMPLE_W-1:0] now;
    } ppdec_event_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ppdec_fifo_status_t;

endpackage

// ===== sv/ppm_pulse_train_decoder_core.sv =====
// Top level of the PPM pulse-train decoder: front end, event queue, back end.
// Depends on ppdec_pkg, ppdec_front, ppdec_fifo and ppdec_back.
//
// Usage:
//   s_* carries one sampled line level per transfer (s_tdata[0]). Every
//   transfer numbers one sample. After a high level and a falling edge, each
//   further falling edge closes a period and yields one result on m_*.
//   m_tuser is 1 for a sync period (high time at or above sync_threshold),
//   0 for a channel period; m_tdata carries high time, channel index, and the
//   first and last sample numbers of the period.
//   sync_threshold is written through cfg_wr_en / cfg_wr_data while idle;
//   it resets to 3000.
// Timing:
//   One input transfer per cycle while the event queue is not full. A closing
//   sample's event is written into the queue when the sample is accepted; the
//   back end pops it from the queue head, and its 48-bit subtract and compare
//   feed straight into the output register that drives m_tvalid.
//   When m_tready is held low, results pile up in the output register and the
//   queue of FIFO_DEPTH events; s_tready drops only when that queue is full.
// Reset:
//   rst_n clears the sample count, phase, channel counter and the queue, and
//   restores the threshold.
module ppm_pulse_train_decoder_core
#(
    parameter int FIFO_DEPTH = ppdec_pkg::FIFO_DEPTH_DEFAULT
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [ppdec_pkg::IN_TDATA_W-1:0]      s_tdata,   // [0] line_level, [7:1] zero
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [31:0] high_time, [39:32] channel_index, [87:40] first_sample, [135:88] last_sample
    output logic [ppdec_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                  m_tuser,   // [0] is_sync
    input  logic                                  cfg_wr_en,
    input  logic [ppdec_pkg::THRESH_W-1:0]        cfg_wr_data
);

    ppdec_pkg::ppdec_event_t       push_event;
    ppdec_pkg::ppdec_event_t       pop_event;
    ppdec_pkg::ppdec_fifo_status_t fifo_status;

    logic                           accept;
    logic                           push;
    logic                           pop;
    logic [ppdec_pkg::HIGH_W-1:0]   high_time;
    logic [ppdec_pkg::CHAN_W-1:0]   channel_index;
    logic [ppdec_pkg::SAMPLE_W-1:0] first_sample;
    logic [ppdec_pkg::SAMPLE_W-1:0] last_sample;

    assign s_tready = !fifo_status.full;
    assign accept   = s_tvalid && s_tready;
    assign m_tdata  = {last_sample, first_sample, channel_index, high_time};

    ppdec_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .level      (s_tdata[0]),
        .push       (push),
        .push_event (push_event)
    );

    ppdec_fifo
    #(
        .DEPTH (FIFO_DEPTH)
    )
    u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_event (push_event),
        .pop        (pop),
        .pop_event  (pop_event),
        .status     (fifo_status)
    );

    ppdec_back u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .fifo_status       (fifo_status),
        .pop_event         (pop_event),
        .pop               (pop),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .out_is_sync       (m_tuser),
        .out_high_time     (high_time),
        .out_channel_index (channel_index),
        .out_first_sample  (first_sample),
        .out_last_sample   (last_sample)
    );

endmodule

// ===== sv/ppdec_front.sv =====
// Front end: counts samples, tracks line phase and emits one event per closed period.
// Depends on ppdec_pkg.
module ppdec_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic                  level,
    output logic                  push,
    output ppdec_pkg::ppdec_event_t push_event
);

    typedef enum logic [1:0] {
        WAIT_HIGH,
        WAIT_FIRST_FALL,
        LOW_PART,
        HIGH_PART
    } phase_t;

    phase_t                          phase_reg;
    logic [ppdec_pkg::SAMPLE_W-1:0]  sample_count_reg;
    logic [ppdec_pkg::SAMPLE_W-1:0]  period_start_reg;
    logic [ppdec_pkg::SAMPLE_W-1:0]  rise_sample_reg;

    assign push             = accept && (phase_reg == HIGH_PART) && !level;
    assign push_event.start = period_start_reg;
    assign push_event.rise  = rise_sample_reg;
    assign push_event.now   = sample_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= WAIT_HIGH;
            sample_count_reg <= '0;
            period_start_reg <= '0;
            rise_sample_reg  <= '0;
        end
        else if (accept)
        begin
            sample_count_reg <= sample_count_reg + ppdec_pkg::SAMPLE_W'(1);
            unique case (phase_reg)
                WAIT_HIGH:
                begin
                    if (level)
                        phase_reg <= WAIT_FIRST_FALL;
                end
                WAIT_FIRST_FALL:
                begin
                    if (!level)
                    begin
                        period_start_reg <= sample_count_reg;
                        phase_reg        <= LOW_PART;
                    end
                end
                LOW_PART:
                begin
                    if (level)
                    begin
                        rise_sample_reg <= sample_count_reg;
                        phase_reg       <= HIGH_PART;
                    end
                end
                HIGH_PART:
                begin
                    if (!level)
                    begin
                        period_start_reg <= sample_count_reg;
                        phase_reg        <= LOW_PART;
                    end
                end
                default:
                begin
                    phase_reg <= WAIT_HIGH;
                end
            endcase
        end
    end

endmodule

// ===== sv/ppdec_fifo.sv =====
// Short event queue between the front end and the back end.
// Depends on ppdec_pkg.
module ppdec_fifo
#(
    parameter int DEPTH = ppdec_pkg::FIFO_DEPTH_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  ppdec_pkg::ppdec_event_t     push_event,
    input  logic                        pop,
    output ppdec_pkg::ppdec_event_t     pop_event,
    output ppdec_pkg::ppdec_fifo_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ppdec_pkg::ppdec_event_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_event    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_event;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                                                                : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

// ===== sv/ppdec_back.sv =====
// Back end: measures high time, classifies sync vs channel, keeps the channel counter
// and holds the output register. Depends on ppdec_pkg.
module ppdec_back
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [ppdec_pkg::THRESH_W-1:0]       cfg_wr_data,
    input  ppdec_pkg::ppdec_fifo_status_t        fifo_status,
    input  ppdec_pkg::ppdec_event_t              pop_event,
    output logic                                 pop,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 out_is_sync,
    output logic [ppdec_pkg::HIGH_W-1:0]         out_high_time,
    output logic [ppdec_pkg::CHAN_W-1:0]         out_channel_index,
    output logic [ppdec_pkg::SAMPLE_W-1:0]       out_first_sample,
    output logic [ppdec_pkg::SAMPLE_W-1:0]       out_last_sample
);

    logic [ppdec_pkg::THRESH_W-1:0] threshold_reg;
    logic [ppdec_pkg::CHAN_W-1:0]   channel_reg;
    logic                           valid_reg;
    logic                           is_sync_reg;
    logic [ppdec_pkg::HIGH_W-1:0]   high_time_reg;
    logic [ppdec_pkg::CHAN_W-1:0]   channel_index_reg;
    logic [ppdec_pkg::SAMPLE_W-1:0] first_sample_reg;
    logic [ppdec_pkg::SAMPLE_W-1:0] last_sample_reg;

    logic [ppdec_pkg::SAMPLE_W-1:0] diff;
    logic                           sync;
    logic [ppdec_pkg::HIGH_W-1:0]   high_sat;

    assign pop  = !fifo_status.empty && (!valid_reg || out_ready);
    assign diff = pop_event.now - pop_event.rise;
    assign sync = diff >= ppdec_pkg::SAMPLE_W'(threshold_reg);
    assign high_sat = (|diff[ppdec_pkg::SAMPLE_W-1:ppdec_pkg::HIGH_W]) ? '1
                                                                       : diff[ppdec_pkg::HIGH_W-1:0];

    assign out_valid         = valid_reg;
    assign out_is_sync       = is_sync_reg;
    assign out_high_time     = high_time_reg;
    assign out_channel_index = channel_index_reg;
    assign out_first_sample  = first_sample_reg;
    assign out_last_sample   = last_sample_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            is_sync_reg       <= sync;
            high_time_reg     <= high_sat;
            channel_index_reg <= sync ? '0 : channel_reg;
            first_sample_reg  <= pop_event.start;
            last_sample_reg   <= pop_event.now - ppdec_pkg::SAMPLE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= ppdec_pkg::THRESH_RESET;
            channel_reg   <= '0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                threshold_reg <= cfg_wr_data;
            if (pop)
            begin
                valid_reg <= 1'b1;
                if (sync)
                    channel_reg <= '0;
                else if (channel_reg != ppdec_pkg::CHAN_MAX)
                    channel_reg <= channel_reg + ppdec_pkg::CHAN_W'(1);
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== sim/ppm_pulse_train_decoder_core_test.sv =====
// Testbench for ppm_pulse_train_decoder_core: drives sampled line levels, predicts
// every closed period and checks each result transfer field by field.
// Depends on ppdec_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module ppm_pulse_train_decoder_core_test;

    localparam int          HOLD_CYCLES    = 64;
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          SETTLE_CYCLES  = 6;
    localparam int unsigned MAX_REPORTS    = 10;

    typedef enum logic [1:0] {
        WAIT_HIGH,
        WAIT_FALL,
        LOW_PART,
        HIGH_PART
    } line_phase_t;

    typedef struct packed {
        logic                           is_sync;
        logic [ppdec_pkg::HIGH_W-1:0]   high_time;
        logic [ppdec_pkg::CHAN_W-1:0]   channel_index;
        logic [ppdec_pkg::SAMPLE_W-1:0] first_sample;
        logic [ppdec_pkg::SAMPLE_W-1:0] last_sample;
    } period_t;

    logic                                clk;
    logic                                rst_n;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [ppdec_pkg::IN_TDATA_W-1:0]    s_tdata  = '0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [ppdec_pkg::OUT_TDATA_W-1:0]   m_tdata;
    logic                                m_tuser;
    logic                                cfg_wr_en;
    logic [ppdec_pkg::THRESH_W-1:0]      cfg_wr_data;

    logic                                line_samples[$];
    period_t                             expected_periods[$];
    int unsigned                         items_queued;

    // decoder state as predicted
    logic [ppdec_pkg::THRESH_W-1:0]      sync_thresh   = ppdec_pkg::THRESH_RESET;
    logic [ppdec_pkg::SAMPLE_W-1:0]      sample_num    = '0;
    line_phase_t                         line_phase    = WAIT_HIGH;
    logic [ppdec_pkg::SAMPLE_W-1:0]      period_open   = '0;
    logic [ppdec_pkg::SAMPLE_W-1:0]      rise_at       = '0;
    logic [ppdec_pkg::CHAN_W-1:0]        chan_count    = '0;

    logic                                in_taken  = 1'b0;
    logic                                idle_on;
    int unsigned                         hold_req;
    int unsigned                         hold_seen = 0;
    int                                  hold_left = 0;
    int                                  quiet_cycles;

    int unsigned                         error_count;
    int unsigned                         samples_taken;
    int unsigned                         sync_periods;
    int unsigned                         chan_periods;
    int unsigned                         saturated_periods;
    int unsigned                         thresh_writes;

    ppm_pulse_train_decoder_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void decode_sample(input logic level);
        logic [ppdec_pkg::SAMPLE_W-1:0] width;
        period_t                        p;
        case (line_phase)
            WAIT_HIGH:
                if (level) line_phase = WAIT_FALL;
            WAIT_FALL:
                if (!level)
                begin
                    period_open = sample_num;
                    line_phase  = LOW_PART;
                end
            LOW_PART:
                if (level)
                begin
                    rise_at    = sample_num;
                    line_phase = HIGH_PART;
                end
            HIGH_PART:
                if (!level)
                begin
                    width           = sample_num - rise_at;
                    p.is_sync       = width >= ppdec_pkg::SAMPLE_W'(sync_thresh);
                    p.high_time     = (width > ppdec_pkg::SAMPLE_W'({ppdec_pkg::HIGH_W{1'b1}}))
                                      ? '1 : width[ppdec_pkg::HIGH_W-1:0];
                    p.channel_index = p.is_sync ? '0 : chan_count;
                    p.first_sample  = period_open;
                    p.last_sample   = sample_num - ppdec_pkg::SAMPLE_W'(1);
                    expected_periods.push_back(p);
                    if (p.is_sync)
                        chan_count = '0;
                    else if (chan_count != ppdec_pkg::CHAN_MAX)
                        chan_count = chan_count + ppdec_pkg::CHAN_W'(1);
                    period_open = sample_num;
                    line_phase  = LOW_PART;
                end
        endcase
        sample_num = sample_num + ppdec_pkg::SAMPLE_W'(1);
    endfunction

    // sender
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (line_samples.size() != 0 && !(idle_on && $urandom_range(99) < 27))
            begin
                s_tdata  <= {{(ppdec_pkg::IN_TDATA_W-1){1'b0}}, line_samples.pop_front()};
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver, with long hold-offs on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                m_tready  <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (hold_req != hold_seen)
            begin
                hold_seen <= hold_req;
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end
            else
                m_tready <= !(idle_on && $urandom_range(99) < 27);
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        period_t got;
        period_t want;
        in_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.is_sync       = m_tuser;
                got.high_time     = m_tdata[ppdec_pkg::HIGH_W-1:0];
                got.channel_index = m_tdata[ppdec_pkg::HIGH_W +: ppdec_pkg::CHAN_W];
                got.first_sample  = m_tdata[ppdec_pkg::HIGH_W+ppdec_pkg::CHAN_W +:
                                            ppdec_pkg::SAMPLE_W];
                got.last_sample   = m_tdata[ppdec_pkg::HIGH_W+ppdec_pkg::CHAN_W+
                                            ppdec_pkg::SAMPLE_W +: ppdec_pkg::SAMPLE_W];
                if (expected_periods.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: unexpected result sync %0d high %0d chan %0d", $realtime,
                                 got.is_sync, got.high_time, got.channel_index);
                end
                else
                begin
                    want = expected_periods.pop_front();
                    if (got.is_sync !== want.is_sync || got.high_time !== want.high_time ||
                        got.channel_index !== want.channel_index ||
                        got.first_sample !== want.first_sample ||
                        got.last_sample !== want.last_sample)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                        begin
                            $write("%0t: mismatch (exp/got) sync %0d/%0d high %0d/%0d",
                                   $realtime, want.is_sync, got.is_sync,
                                   want.high_time, got.high_time);
                            $display(" chan %0d/%0d first %0d/%0d last %0d/%0d",
                                     want.channel_index, got.channel_index,
                                     want.first_sample, got.first_sample,
                                     want.last_sample, got.last_sample);
                        end
                    end
                    if (want.is_sync)
                        sync_periods++;
                    else
                        chan_periods++;
                    if (!want.is_sync && want.channel_index == ppdec_pkg::CHAN_MAX)
                        saturated_periods++;
                end
            end
            if (s_tvalid && s_tready)
            begin
                decode_sample(s_tdata[0]);
                samples_taken++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic add_level(input logic level, input int unsigned n);
        repeat (n) line_samples.push_back(level);
        items_queued += n;
    endtask

    task automatic add_pulse(input int unsigned low_n, input int unsigned high_n);
        add_level(1'b0, low_n);
        add_level(1'b1, high_n);
    endtask

    // mostly well-formed frames around the given sync width, some noise and broken runs
    task automatic add_frames(input int unsigned sync_w, input int unsigned n);
        int unsigned stop_at;
        int unsigned r;
        stop_at = items_queued + n;
        while (items_queued < stop_at)
        begin
            r = $urandom_range(99);
            if (r < 80)
            begin
                add_pulse($urandom_range(1, 4), $urandom_range(sync_w, sync_w + 6));
                repeat ($urandom_range(1, 12))
                    add_pulse($urandom_range(1, 4),
                              $urandom_range(1, (sync_w > 1) ? sync_w - 1 : 1));
            end
            else if (r < 92)
                repeat ($urandom_range(1, 20)) add_level(1'($urandom_range(0, 1)), 1);
            else if (r < 96)
                add_level(1'b1, $urandom_range(sync_w, sync_w + 40));
            else
                add_level(1'b0, $urandom_range(5, 30));
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (line_samples.size() != 0 || s_tvalid || expected_periods.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_threshold(input logic [ppdec_pkg::THRESH_W-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        sync_thresh = value;
        thresh_writes++;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        int unsigned thr;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        idle_on     = 1'b1;
        hold_req    = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // directed, reset threshold: lows before any high are ignored, then
        // short channel periods
        add_level(1'b0, 2);
        add_level(1'b1, 2);
        add_level(1'b0, 1);
        add_level(1'b1, 1);
        add_pulse(1, 2);
        add_pulse(3, 1);
        add_pulse(1, 4);
        add_pulse(2, 1);
        add_pulse(1, 1);
        add_level(1'b0, 1);

        // zero threshold: every period is sync
        set_threshold('0);
        add_frames(3, 150);

        // all-ones threshold, no idling: channel index runs into saturation
        set_threshold('1);
        idle_on = 1'b0;
        repeat (280) add_pulse(1, $urandom_range(1, 2));

        // typical frames; receiver holds off while the sender keeps offering
        set_threshold($urandom_range(3, 16));
        idle_on = 1'b1;
        add_frames(sync_thresh, 500);
        @(posedge clk);
        hold_req++;

        // pure noise against a tiny threshold
        set_threshold($urandom_range(1, 4));
        repeat (200) add_level(1'($urandom_range(0, 1)), 1);

        thr = $urandom_range(3, 16);
        set_threshold(thr);
        add_frames(thr, 250);
        @(posedge clk);
        hold_req++;

        wait_idle();
        error_count += expected_periods.size();
        $display("covered %0d line samples, %0d channel and %0d sync periods over %0d thresholds",
                 samples_taken, chan_periods, sync_periods, thresh_writes);
        $display("%0d channel periods at the saturated index, %0d failures",
                 saturated_periods, error_count);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
